@@ rtl/csr_spmv_pkg.sv @@
// ----------------------------------------------------------------------------
// csr_spmv_pkg
// Shared widths, codes and record types of the dense-row to CSR SpMV block.
// ----------------------------------------------------------------------------
package csr_spmv_pkg;

   localparam int VAL_W       = 32;
   localparam int COL_W       = 11;
   localparam int ROW_W       = 11;
   localparam int CNT_W       = 23;
   localparam int DOT_W       = 64;
   localparam int CFG_W       = 12;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'b1;

   localparam logic FUNC_VEC_WRITE = 1'b0;
   localparam logic FUNC_MATRIX    = 1'b1;

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_ROW_END = 1'b1;

   // one matrix element on its way to the multiply-accumulate
   typedef struct packed {
      logic                    row_end;
      logic                    nonzero;
      logic signed [VAL_W-1:0] value;
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic [CNT_W-1:0]        count;
   } elem_type;

   // everything one matrix element produces: an entry, a row result, or both
   typedef struct packed {
      logic                    has_entry;
      logic                    has_row;
      logic signed [VAL_W-1:0] value;
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic [CNT_W-1:0]        count;
      logic signed [DOT_W-1:0] dot;
   } rec_type;

endpackage

@@ rtl/csr_spmv_ram.sv @@
// ----------------------------------------------------------------------------
// csr_spmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csr_spmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/csr_spmv_mac.sv @@
// ----------------------------------------------------------------------------
// csr_spmv_mac
// Two-stage multiply-accumulate: element times vector word, then row sum.
// ----------------------------------------------------------------------------
module csr_spmv_mac
   import csr_spmv_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  elem_valid,
   input  elem_type              elem,
   input  logic [VALUE_BITS-1:0] vec_word,
   output logic                  push,
   output rec_type               rec,
   output logic [1:0]            inflight
);

   logic                    s1_valid_ff;
   elem_type                s1_elem_ff;
   logic                    s2_valid_ff;
   elem_type                s2_elem_ff;
   logic signed [DOT_W-1:0] s2_prod_ff;
   logic signed [DOT_W-1:0] acc_ff;
   logic signed [DOT_W-1:0] acc_in;
   logic signed [DOT_W-1:0] acc_sum;
   logic signed [VAL_W-1:0] mul_a;
   logic signed [VAL_W-1:0] mul_b;
   logic signed [DOT_W-1:0] prod_in;

   // vector word read data lines up with stage one
   assign mul_a   = s1_elem_ff.value;
   assign mul_b   = VAL_W'(signed'(vec_word));
   assign prod_in = mul_a * mul_b;

   assign acc_sum = acc_ff + s2_prod_ff;

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_elem_ff.row_end ? '0 : acc_sum;
      end
   end

   always_comb begin
      rec.has_entry = s2_elem_ff.nonzero;
      rec.has_row   = s2_elem_ff.row_end;
      rec.value     = s2_elem_ff.value;
      rec.col       = s2_elem_ff.col;
      rec.row       = s2_elem_ff.row;
      rec.count     = s2_elem_ff.count;
      rec.dot       = acc_sum;
   end

   assign push     = s2_valid_ff && (s2_elem_ff.nonzero || s2_elem_ff.row_end);
   assign inflight = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= elem_valid;
         s2_valid_ff <= s1_valid_ff;
         acc_ff      <= acc_in;
      end
      s1_elem_ff <= elem;
      s2_elem_ff <= s1_elem_ff;
      s2_prod_ff <= prod_in;
   end

   // row sum starts over after every row result
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_elem_ff.row_end) |=> (acc_ff == '0))
      else $error("row sum not cleared after row end");

   // a zero element adds nothing to the row sum
   a_zero_no_add: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_elem_ff.nonzero) |=> (s2_prod_ff == '0))
      else $error("zero element gave a nonzero product");

endmodule

@@ rtl/csr_spmv_outq.sv @@
// ----------------------------------------------------------------------------
// csr_spmv_outq
// Result queue: holds per-element records and plays out one or two results.
// ----------------------------------------------------------------------------
module csr_spmv_outq
   import csr_spmv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rec_type                 rec,
   output logic [QCNT_W-1:0]       count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_out_kind,
   output logic signed [VAL_W-1:0] rsp_entry_value,
   output logic [COL_W-1:0]        rsp_column_index,
   output logic [ROW_W-1:0]        rsp_row_number,
   output logic [CNT_W-1:0]        rsp_row_end_count,
   output logic signed [DOT_W-1:0] rsp_row_dot,
   output logic                    rsp_last_of_run
);

   rec_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               phase_ff;
   logic               phase_in;
   rec_type            head;
   logic               both;
   logic               show_entry;
   logic               rsp_go;
   logic               pop;

   assign head       = queue_ff[rd_ptr_ff];
   assign both       = head.has_entry && head.has_row;
   // entry goes first; the row result follows in phase one
   assign show_entry = head.has_entry && !phase_ff;

   assign rsp_valid  = (count_ff != '0);
   assign rsp_go     = rsp_valid && !rsp_stall;
   assign pop        = rsp_go && (phase_ff || !both);
   assign count      = count_ff;

   always_comb begin
      phase_in = phase_ff;
      if (rsp_go) begin
         phase_in = both && !phase_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      if (show_entry) begin
         rsp_out_kind      = KIND_ENTRY;
         rsp_entry_value   = head.value;
         rsp_column_index  = head.col;
         rsp_row_end_count = '0;
         rsp_row_dot       = '0;
      end else begin
         rsp_out_kind      = KIND_ROW_END;
         rsp_entry_value   = '0;
         rsp_column_index  = '0;
         rsp_row_end_count = head.count;
         rsp_row_dot       = head.dot;
      end
      rsp_row_number  = head.row;
      rsp_last_of_run = !(both && !phase_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == QCNT_W'(QUEUE_DEPTH))))
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count out of range");

   // second phase only on a record that carries both results
   a_phase_both: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (rsp_valid && both))
      else $error("row phase on a single-result record");

endmodule

@@ rtl/dense_row_to_csr_spmv_top.sv @@
// ----------------------------------------------------------------------------
// dense_row_to_csr_spmv_top
// Dense row-major matrix stream to CSR entries and row dot products.
// ----------------------------------------------------------------------------
// result path: a matrix request passes the memory read and multiply stage, the
// accumulate stage and the result queue; a row result follows its record's entry
// throughput: one request per cycle; the input stalls once queued records plus
// those in the multiply-accumulate reach the 8-entry result queue depth
// reset: counters, row sum and queue clear at once; vector memory is not
// cleared and must be written before it is read
module dense_row_to_csr_spmv_top
   import csr_spmv_pkg::*;
#(
   parameter int MAX_COLS   = 2048,
   parameter int MAX_ROWS   = 2048,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [COL_W-1:0]        req_vec_index,
   input  logic signed [VAL_W-1:0] req_element_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_out_kind,
   output logic signed [VAL_W-1:0] rsp_entry_value,
   output logic [COL_W-1:0]        rsp_column_index,
   output logic [ROW_W-1:0]        rsp_row_number,
   output logic [CNT_W-1:0]        rsp_row_end_count,
   output logic signed [DOT_W-1:0] rsp_row_dot,
   output logic                    rsp_last_of_run,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   localparam int AW     = $clog2(MAX_COLS);
   localparam int NC_W   = $clog2(MAX_COLS + 1);
   localparam int NR_W   = $clog2(MAX_ROWS + 1);
   localparam int NC_RST = (MAX_COLS < 2048) ? MAX_COLS : 2048;
   localparam int NR_RST = (MAX_ROWS < 2048) ? MAX_ROWS : 2048;

   logic [NC_W-1:0]         num_cols_ff;
   logic [NR_W-1:0]         num_rows_ff;
   logic [NC_W-1:0]         cols_cfg;
   logic [NR_W-1:0]         rows_cfg;
   logic [AW-1:0]           col_ff;
   logic [AW-1:0]           col_in;
   logic [NR_W-1:0]         row_ff;
   logic [NR_W-1:0]         row_in;
   logic [CNT_W-1:0]        total_ff;
   logic [CNT_W-1:0]        total_in;
   logic [CNT_W-1:0]        total_inc;
   logic                    accept;
   logic                    vec_we;
   logic                    elem_go;
   logic signed [VAL_W-1:0] value_sx;
   logic                    nonzero;
   logic                    row_end;
   logic [31:0]             row_inc;
   logic                    row_wrap;
   elem_type                elem;
   logic [VALUE_BITS-1:0]   vec_word;
   logic                    push;
   rec_type                 rec;
   logic [1:0]              inflight;
   logic [QCNT_W-1:0]       q_count;

   // zero acts as one, oversize saturates
   always_comb begin
      if (csr_wdata == '0) begin
         cols_cfg = NC_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_COLS)) begin
         cols_cfg = NC_W'(MAX_COLS);
      end else begin
         cols_cfg = NC_W'(csr_wdata);
      end
      if (csr_wdata == '0) begin
         rows_cfg = NR_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_ROWS)) begin
         rows_cfg = NR_W'(MAX_ROWS);
      end else begin
         rows_cfg = NR_W'(csr_wdata);
      end
   end

   assign req_stall = (32'(q_count) + 32'(inflight) + 32'd1) > 32'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign vec_we    = accept && (req_func == FUNC_VEC_WRITE)
                      && (32'(req_vec_index) < 32'(MAX_COLS));
   assign elem_go   = accept && (req_func == FUNC_MATRIX);

   assign value_sx  = VAL_W'(signed'(req_element_value[VALUE_BITS-1:0]));
   assign nonzero   = (value_sx != '0);
   assign row_end   = (32'(col_ff) + 32'd1) >= 32'(num_cols_ff);
   assign total_inc = nonzero ? total_ff + 1'b1 : total_ff;
   assign row_inc   = 32'(row_ff) + 32'd1;
   assign row_wrap  = row_inc >= 32'(num_rows_ff);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      total_in = total_ff;
      if (elem_go) begin
         total_in = total_inc;
         if (row_end) begin
            col_in = '0;
            if (row_wrap) begin
               row_in   = '0;
               total_in = '0;
            end else begin
               row_in = NR_W'(row_inc);
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      elem.row_end = row_end;
      elem.nonzero = nonzero;
      elem.value   = value_sx;
      elem.col     = COL_W'(col_ff);
      elem.row     = ROW_W'(row_ff);
      elem.count   = total_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= NC_W'(NC_RST);
         num_rows_ff <= NR_W'(NR_RST);
         col_ff      <= '0;
         row_ff      <= '0;
         total_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NUM_COLS: num_cols_ff <= cols_cfg;
               CSR_NUM_ROWS: num_rows_ff <= rows_cfg;
               default: ;
            endcase
         end
         col_ff   <= col_in;
         row_ff   <= row_in;
         total_ff <= total_in;
      end
   end

   // write and read happen at acceptance, so a word written by one request is
   // seen by any later matrix request without forwarding
   csr_spmv_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_COLS)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (AW'(req_vec_index)),
      .wr_data (req_element_value[VALUE_BITS-1:0]),
      .rd_addr (col_ff),
      .rd_data (vec_word)
   );

   csr_spmv_mac #(
      .VALUE_BITS (VALUE_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .elem_valid (elem_go),
      .elem       (elem),
      .vec_word   (vec_word),
      .push       (push),
      .rec        (rec),
      .inflight   (inflight)
   );

   csr_spmv_outq u_outq (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .rec               (rec),
      .count             (q_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_column_index  (rsp_column_index),
      .rsp_row_number    (rsp_row_number),
      .rsp_row_end_count (rsp_row_end_count),
      .rsp_row_dot       (rsp_row_dot),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

@@ sim/csr_spmv_checker.sv @@
// ----------------------------------------------------------------------------
// csr_spmv_checker
// Watches the request, result and register ports of the CSR SpMV block, keeps
// its own copy of the vector memory, counters and sizes, works out the entries
// and row results that each accepted request must give, and compares them in
// order with the results the block delivers.
// ----------------------------------------------------------------------------
module csr_spmv_checker
   import csr_spmv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_func,
   input  logic [COL_W-1:0]        req_vec_index,
   input  logic signed [VAL_W-1:0] req_element_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_out_kind,
   input  logic signed [VAL_W-1:0] rsp_entry_value,
   input  logic [COL_W-1:0]        rsp_column_index,
   input  logic [ROW_W-1:0]        rsp_row_number,
   input  logic [CNT_W-1:0]        rsp_row_end_count,
   input  logic signed [DOT_W-1:0] rsp_row_dot,
   input  logic                    rsp_last_of_run,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS = 2048;
   localparam int MAX_ROWS = 2048;

   typedef struct {
      logic                    kind;
      logic signed [VAL_W-1:0] value;
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic [CNT_W-1:0]        count;
      logic signed [DOT_W-1:0] dot;
      logic                    last;
   } csr_output_type;

   csr_output_type          csr_out_queue[$];
   logic signed [VAL_W-1:0] vector_words[MAX_COLS];
   int                      col_pos;
   int                      row_pos;
   logic [CNT_W-1:0]        nonzero_seen;
   logic signed [DOT_W-1:0] row_sum;
   int                      cols_in_use;
   int                      rows_in_use;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int clamp_size(logic [CFG_W-1:0] raw, int top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   // one request: a vector load, or a matrix element giving an entry and/or a row end
   task automatic run_spmv_step(logic func, logic [COL_W-1:0] idx,
                                logic signed [VAL_W-1:0] v);
      csr_output_type res;
      logic           row_done;
      if (func == FUNC_VEC_WRITE) begin
         vector_words[idx] = v;
         return;
      end
      row_done = (col_pos + 1 >= cols_in_use);
      if (v != 0) begin
         row_sum      = row_sum + longint'(v) * longint'(vector_words[col_pos % MAX_COLS]);
         nonzero_seen = nonzero_seen + 1'b1;
         res.kind  = KIND_ENTRY;
         res.value = v;
         res.col   = COL_W'(col_pos);
         res.row   = ROW_W'(row_pos);
         res.count = '0;
         res.dot   = '0;
         res.last  = !row_done;
         csr_out_queue.push_back(res);
      end
      if (row_done) begin
         res.kind  = KIND_ROW_END;
         res.value = '0;
         res.col   = '0;
         res.row   = ROW_W'(row_pos);
         res.count = nonzero_seen;
         res.dot   = row_sum;
         res.last  = 1'b1;
         csr_out_queue.push_back(res);
         row_sum = '0;
         col_pos = 0;
         row_pos++;
         if (row_pos >= rows_in_use) begin
            row_pos      = 0;
            nonzero_seen = '0;
         end
      end else begin
         col_pos++;
      end
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      csr_output_type want;
      if (reset) begin
         csr_out_queue.delete();
         col_pos      = 0;
         row_pos      = 0;
         nonzero_seen = '0;
         row_sum      = '0;
         cols_in_use  = MAX_COLS;
         rows_in_use  = MAX_ROWS;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (csr_out_queue.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual kind %0d row %0d",
                        $time, rsp_out_kind, rsp_row_number);
               fail_count++;
            end else begin
               want = csr_out_queue.pop_front();
               check_field("out_kind", 64'(want.kind), 64'(rsp_out_kind));
               check_field("entry_value", 64'(want.value), 64'(rsp_entry_value));
               check_field("column_index", 64'(want.col), 64'(rsp_column_index));
               check_field("row_number", 64'(want.row), 64'(rsp_row_number));
               check_field("row_end_count", 64'(want.count), 64'(rsp_row_end_count));
               check_field("row_dot", want.dot, rsp_row_dot);
               check_field("last_of_run", 64'(want.last), 64'(rsp_last_of_run));
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_NUM_COLS) cols_in_use = clamp_size(csr_wdata, MAX_COLS);
            else if (csr_index == CSR_NUM_ROWS) rows_in_use = clamp_size(csr_wdata, MAX_ROWS);
         end
         if (req_valid && !req_stall)
            run_spmv_step(req_func, req_vec_index, req_element_value);
      end
      pending = csr_out_queue.size();
   end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the CSR SpMV block with vector loads and row-major matrix elements
// under changing row and column sizes, random idling on both channels and one
// long result hold-off; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench
   import csr_spmv_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS     = 2048;
   localparam int ITEM_TARGET  = 1975;
   localparam int QUIET_FROM   = 1775;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_func = FUNC_VEC_WRITE;
   logic [COL_W-1:0]        req_vec_index = '0;
   logic signed [VAL_W-1:0] req_element_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_out_kind;
   logic signed [VAL_W-1:0] rsp_entry_value;
   logic [COL_W-1:0]        rsp_column_index;
   logic [ROW_W-1:0]        rsp_row_number;
   logic [CNT_W-1:0]        rsp_row_end_count;
   logic signed [DOT_W-1:0] rsp_row_dot;
   logic                    rsp_last_of_run;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_NUM_COLS;
   logic [CFG_W-1:0]        csr_wdata = '0;
   int                      fail_count;
   int                      pending;

   // stimulus bookkeeping: which vector words hold data and where the row stands
   bit                      vec_loaded[MAX_COLS];
   int                      col_at = 0;
   int                      cols_now = MAX_COLS;
   int                      items_total = 0;
   int                      req_idle_pct = 10;
   bit                      quiet = 1'b0;
   bit                      long_hold_req = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   dense_row_to_csr_spmv_top dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_vec_index, .req_element_value,
      .rsp_valid, .rsp_stall, .rsp_out_kind, .rsp_entry_value, .rsp_column_index,
      .rsp_row_number, .rsp_row_end_count, .rsp_row_dot, .rsp_last_of_run,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   csr_spmv_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_vec_index, .req_element_value,
      .rsp_valid, .rsp_stall, .rsp_out_kind, .rsp_entry_value, .rsp_column_index,
      .rsp_row_number, .rsp_row_end_count, .rsp_row_dot, .rsp_last_of_run,
      .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending
   );

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return '0;
         3:       return 32'h8000_0000;
         4:       return 32'h7FFF_FFFF;
         5:       return 32'hFFFF_FFFF;
         6:       return $urandom_range(1, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic func, logic [COL_W-1:0] idx, logic [VAL_W-1:0] v);
      int gap;
      if (!quiet && $urandom_range(0, 99) < req_idle_pct) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_func          <= func;
      req_vec_index     <= idx;
      req_element_value <= v;
      do @(posedge clock); while (req_stall);
      if (func == FUNC_VEC_WRITE) vec_loaded[idx] = 1'b1;
      items_total++;
   endtask

   // a matrix element; loads the vector word of its column first if still empty
   task automatic send_element(logic [VAL_W-1:0] v);
      if (!vec_loaded[col_at]) send_request(FUNC_VEC_WRITE, COL_W'(col_at), pick_value());
      send_request(FUNC_MATRIX, COL_W'($urandom), v);
      col_at = (col_at + 1 >= cols_now) ? 0 : col_at + 1;
   endtask

   task automatic settle();
      int waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic program_sizes(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_NUM_COLS;
      csr_wdata <= cols;
      @(negedge clock);
      csr_index <= CSR_NUM_ROWS;
      csr_wdata <= rows;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cols_now = (cols == 0) ? 1 : ((int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols));
   endtask

   // result side: random stall bursts, calm stretches and one long hold-off
   initial begin
      int stall_left;
      int stall_pct;
      int tick;
      stall_left = 0;
      stall_pct  = 10;
      tick       = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               default: stall_pct = 30;
            endcase
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = 299;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #15_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int phase_len;
      logic [CFG_W-1:0] cols, rows;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset sizes: extreme vector words and elements, row left open
      send_request(FUNC_VEC_WRITE, 11'd0, 32'h7FFF_FFFF);
      send_request(FUNC_VEC_WRITE, 11'd1, 32'h8000_0000);
      send_request(FUNC_VEC_WRITE, 11'd2, 32'hFFFF_FFFF);
      send_request(FUNC_VEC_WRITE, 11'd2047, 32'h0000_0001);
      send_element(32'h8000_0000);
      send_element(32'h7FFF_FFFF);
      send_element(32'h0000_0000);

      // shrink the row while three columns are in: next element closes it
      program_sizes(12'd4, 12'd3);
      send_element(32'h0000_0005);
      for (int i = 0; i < 4; i++) send_request(FUNC_VEC_WRITE, COL_W'(i), 32'h8000_0000);
      // four times 2^62 wraps the row sum to zero
      repeat (4) send_element(32'h8000_0000);
      // all-zero row closes the run of three rows
      repeat (4) send_element(32'h0000_0000);

      // zero registers act as one
      program_sizes(12'd0, 12'd0);
      send_element(32'h0000_0000);
      send_element(32'hFFFF_FFFF);

      // oversized registers saturate
      program_sizes(12'hFFF, 12'hFFF);
      send_element(32'h7FFF_FFFF);
      send_element(32'h0000_0000);

      // long result hold-off while requests keep coming: the queue fills up
      long_hold_req = 1'b1;
      repeat (40) send_element(32'h0000_0003);

      while (items_total < ITEM_TARGET) begin
         case ($urandom_range(0, 15))
            0:       cols = 12'd0;
            1:       cols = CFG_W'($urandom_range(2049, 4095));
            2, 3:    cols = CFG_W'($urandom_range(9, 64));
            default: cols = CFG_W'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 15))
            0:       rows = 12'd0;
            1:       rows = CFG_W'($urandom_range(2049, 4095));
            2, 3:    rows = CFG_W'($urandom_range(8, 40));
            default: rows = CFG_W'($urandom_range(1, 6));
         endcase
         program_sizes(cols, rows);
         case ($urandom_range(0, 2))
            0:       req_idle_pct = 0;
            1:       req_idle_pct = 10;
            default: req_idle_pct = 40;
         endcase
         phase_len = $urandom_range(20, 120);
         for (int i = 0; i < phase_len && items_total < ITEM_TARGET; i++) begin
            if (items_total >= QUIET_FROM) quiet = 1'b1;
            if ($urandom_range(0, 6) == 0)
               send_request(FUNC_VEC_WRITE, COL_W'($urandom_range(0, MAX_COLS - 1)),
                            pick_value());
            else
               send_element(pick_value());
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
